// ===== design/ktlmc_pkg.sv =====
`timescale 1ns / 1ps

package ktlmc_pkg;

  localparam int TABLE_ROWS = 16;
  localparam int ROW_W      = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int IDX_W      = 4;
  localparam int ID_W       = 64;
  localparam int REV_W      = 64;
  localparam int KIND_W     = 2;
  localparam int VAR_W      = 16;
  localparam int STATUS_W   = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REV_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd2;

  typedef struct packed {
    logic [VAR_W-1:0]  variant;
    logic [KIND_W-1:0] kind;
    logic [REV_W-1:0]  revision;
    logic [ID_W-1:0]   identity;
  } row_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [ROW_W-1:0] addr;
    row_t             wdata;
  } mem_req_t;

endpackage

// ===== design/ktlmc_row_mem.sv =====
`timescale 1ns / 1ps

module ktlmc_row_mem
  import ktlmc_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output row_t     rdata
);

  row_t mem [TABLE_ROWS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== design/ktlmc_ctrl.sv =====
`timescale 1ns / 1ps

module ktlmc_ctrl
  import ktlmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [IDX_W-1:0]    in_row,
  input  logic                in_row_valid,
  input  row_t                in_key,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] res_status,
  output logic [IDX_W-1:0]    res_index,
  output mem_req_t            mem_req,
  input  row_t                mem_rdata
);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t           state;
  logic             entry_valid [TABLE_ROWS];
  row_t             key;
  logic [ROW_W-1:0] rd_ptr;
  logic             issued_all;
  logic             cmp_vld;
  logic [ROW_W-1:0] cmp_idx;
  logic             cmp_row_valid;
  logic             id_seen;
  logic             rev_seen;

  logic             accept;
  logic             row_ok;
  logic [ROW_W-1:0] wr_row;
  logic             start_scan;
  logic             id_m;
  logic             rev_m;
  logic             full_m;

  assign in_ready  = (state == IDLE);
  assign res_valid = (state == DONE);
  assign accept    = in_valid && in_ready;
  assign row_ok    = 32'(in_row) < TABLE_ROWS;
  assign wr_row    = ROW_W'({{ROW_W{1'b0}}, in_row});
  assign start_scan = accept && (in_opcode == OP_QUERY) && (in_key.identity != '0);

  always_comb begin
    mem_req.wr_en = accept && (in_opcode == OP_WRITE) && row_ok && in_row_valid;
    mem_req.rd_en = start_scan || ((state == SCAN) && !issued_all);
    mem_req.addr  = '0;
    if (accept && (in_opcode == OP_WRITE)) begin
      mem_req.addr = wr_row;
    end else if (state == SCAN) begin
      mem_req.addr = rd_ptr;
    end
    mem_req.wdata = in_key;
  end

  // compare the row that came back from memory against the held query
  assign id_m   = cmp_vld && cmp_row_valid && (mem_rdata.identity == key.identity);
  assign rev_m  = id_m && (mem_rdata.revision == key.revision);
  assign full_m = rev_m && (mem_rdata.kind == key.kind) && (mem_rdata.variant == key.variant);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ROWS; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (accept && (in_opcode == OP_WRITE) && row_ok) begin
      entry_valid[wr_row] <= in_row_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cmp_vld    <= 1'b0;
      issued_all <= 1'b0;
      id_seen    <= 1'b0;
      rev_seen   <= 1'b0;
      rd_ptr     <= '0;
    end else begin
      cmp_vld <= mem_req.rd_en;
      if (mem_req.rd_en) begin
        cmp_idx       <= mem_req.addr;
        cmp_row_valid <= entry_valid[mem_req.addr];
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            key        <= in_key;
            id_seen    <= 1'b0;
            rev_seen   <= 1'b0;
            rd_ptr     <= ROW_W'(1);
            issued_all <= (TABLE_ROWS == 1);
            res_index  <= '0;
            if (in_opcode == OP_WRITE) begin
              res_status <= ST_HIT;
              state      <= DONE;
            end else if (!start_scan) begin
              res_status <= ST_UNKNOWN;
              state      <= DONE;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (!issued_all) begin
            rd_ptr <= rd_ptr + ROW_W'(1);
            if (32'(rd_ptr) == TABLE_ROWS - 1) begin
              issued_all <= 1'b1;
            end
          end
          if (cmp_vld) begin
            id_seen  <= id_seen || id_m;
            rev_seen <= rev_seen || rev_m;
            if (full_m) begin
              res_status <= ST_HIT;
              res_index  <= IDX_W'({{IDX_W{1'b0}}, cmp_idx});
              state      <= DONE;
            end else if (32'(cmp_idx) == TABLE_ROWS - 1) begin
              res_index <= '0;
              if (rev_seen || rev_m) begin
                res_status <= ST_UNKNOWN;
              end else if (id_seen || id_m) begin
                res_status <= ST_REV_MISS;
              end else begin
                res_status <= ST_UNKNOWN;
              end
              state <= DONE;
            end
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== design/keyed_table_lookup_miss_class.sv =====
`timescale 1ns / 1ps
// write or zero-identity query: result set on acceptance, then put in the output register
// query: rows are read one per cycle from the row memory, from row 0 up; the scan ends
// at the first full match (lowest row wins) or after the last row is compared
// one transaction in flight; the next is taken the cycle after the result is registered
// rst (synchronous) clears the row valid marks, the sequencer and the output valid

module keyed_table_lookup_miss_class
  import ktlmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // row_index[3:0], row_valid[4], identity[68:5], revision[132:69],
  // draw_kind[134:133], variant_code[150:135], zero[151]
  input  logic [151:0] s_tdata,
  // opcode[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], hit_index[5:2], zero[7:6]
  output logic [7:0]   m_tdata
);

  row_t                in_key;
  mem_req_t            mem_req;
  row_t                mem_rdata;
  logic                res_valid;
  logic                res_ready;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_index;

  assign in_key.identity = s_tdata[68:5];
  assign in_key.revision = s_tdata[132:69];
  assign in_key.kind     = s_tdata[134:133];
  assign in_key.variant  = s_tdata[150:135];

  assign res_ready = !m_tvalid || m_tready;

  ktlmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_opcode    (s_tuser[0]),
    .in_row       (s_tdata[3:0]),
    .in_row_valid (s_tdata[4]),
    .in_key       (in_key),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_status   (res_status),
    .res_index    (res_index),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  ktlmc_row_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {2'b00, res_index, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("row memory read and written in the same cycle");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == OP_QUERY) && (s_tdata[68:5] != '0))
    |=> !s_tready)
    else $error("new transaction accepted during a scan");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != ST_HIT)) |-> (m_tdata[5:2] == '0))
    else $error("miss carries a nonzero row index");

  a_result_loads_once: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> !res_valid)
    else $error("result offered twice");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ktlmc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 720;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 317;

  typedef struct {
    logic              op;
    logic [3:0]        row;
    logic              row_valid;
    logic [ID_W-1:0]   ident;
    logic [REV_W-1:0]  rev;
    logic [KIND_W-1:0] kind;
    logic [VAR_W-1:0]  variant;
  } table_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    hit_index;
  } lookup_outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  keyed_table_lookup_miss_class u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor copy of the row table
  logic              tbl_valid [TABLE_ROWS] = '{default: 1'b0};
  logic [ID_W-1:0]   tbl_id    [TABLE_ROWS];
  logic [REV_W-1:0]  tbl_rev   [TABLE_ROWS];
  logic [KIND_W-1:0] tbl_kind  [TABLE_ROWS];
  logic [VAR_W-1:0]  tbl_var   [TABLE_ROWS];

  // keys handed out by the generator, used to build queries that match
  logic              gen_written [16] = '{default: 1'b0};
  logic [ID_W-1:0]   gen_id      [16];
  logic [REV_W-1:0]  gen_rev     [16];
  logic [KIND_W-1:0] gen_kind    [16];
  logic [VAR_W-1:0]  gen_var     [16];
  logic [ID_W-1:0]   id_pool     [4];
  logic [REV_W-1:0]  rev_pool    [3];

  table_cmd_t      cmd_queue [$];
  lookup_outcome_t outcome_q [$];
  table_cmd_t      cur_cmd;
  table_cmd_t      next_cmd;
  lookup_outcome_t got_outcome;
  lookup_outcome_t want_outcome;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int result_count  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycle_count   = 0;

  function automatic lookup_outcome_t table_op_outcome(table_cmd_t c);
    lookup_outcome_t o;
    logic id_seen;
    logic rev_seen;
    logic found;
    o.status    = ST_HIT;
    o.hit_index = '0;
    id_seen     = 1'b0;
    rev_seen    = 1'b0;
    found       = 1'b0;
    if (c.op == OP_WRITE) begin
      if (int'(c.row) < TABLE_ROWS) begin
        if (c.row_valid) begin
          tbl_id[c.row]    = c.ident;
          tbl_rev[c.row]   = c.rev;
          tbl_kind[c.row]  = c.kind;
          tbl_var[c.row]   = c.variant;
          tbl_valid[c.row] = 1'b1;
        end else begin
          tbl_valid[c.row] = 1'b0;
        end
      end
    end else if (c.ident == '0) begin
      o.status = ST_UNKNOWN;
    end else begin
      for (int i = 0; i < TABLE_ROWS; i++) begin
        if (!found && tbl_valid[i] && tbl_id[i] == c.ident) begin
          id_seen = 1'b1;
          if (tbl_rev[i] == c.rev) begin
            rev_seen = 1'b1;
            if (tbl_kind[i] == c.kind && tbl_var[i] == c.variant) begin
              found       = 1'b1;
              o.hit_index = i[IDX_W-1:0];
            end
          end
        end
      end
      if (!found) begin
        if (rev_seen) o.status = ST_UNKNOWN;
        else if (id_seen) o.status = ST_REV_MISS;
        else o.status = ST_UNKNOWN;
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] pick_ident();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 88) return id_pool[2'($urandom_range(3))];
    return rand64();
  endfunction

  function automatic logic [REV_W-1:0] pick_rev();
    if ($urandom_range(99) < 85) return rev_pool[2'($urandom_range(2))];
    return rand64();
  endfunction

  function automatic logic [VAR_W-1:0] pick_variant();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 16'h0000;
    if (r < 50) return 16'hFFFF;
    if (r < 70) return 16'h0001;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic push_cmd(logic op, logic [3:0] row, logic rv, logic [ID_W-1:0] ident,
                          logic [REV_W-1:0] rev, logic [KIND_W-1:0] kind,
                          logic [VAR_W-1:0] variant);
    table_cmd_t c;
    c.op        = op;
    c.row       = row;
    c.row_valid = rv;
    c.ident     = ident;
    c.rev       = rev;
    c.kind      = kind;
    c.variant   = variant;
    cmd_queue.push_back(c);
  endtask

  // mostly writes from small key pools and queries built from written keys,
  // some with one field disturbed, plus fully random noise
  function automatic table_cmd_t make_random_cmd();
    table_cmd_t c;
    int r;
    logic [3:0] pick;
    c.row       = 4'($urandom_range(15));
    c.row_valid = 1'($urandom_range(1));
    c.ident     = pick_ident();
    c.rev       = pick_rev();
    c.kind      = 2'($urandom_range(3));
    c.variant   = pick_variant();
    if ($urandom_range(99) < 45) begin
      c.op        = OP_WRITE;
      c.row_valid = ($urandom_range(99) < 75);
      if (c.row_valid) begin
        gen_written[c.row] = 1'b1;
        gen_id[c.row]      = c.ident;
        gen_rev[c.row]     = c.rev;
        gen_kind[c.row]    = c.kind;
        gen_var[c.row]     = c.variant;
      end
    end else begin
      c.op = OP_QUERY;
      pick = 4'($urandom_range(15));
      if (gen_written[pick] && $urandom_range(99) < 85) begin
        c.ident   = gen_id[pick];
        c.rev     = gen_rev[pick];
        c.kind    = gen_kind[pick];
        c.variant = gen_var[pick];
        r = $urandom_range(99);
        if (r >= 95) c.ident = '0;
        else if (r >= 85) c.ident = pick_ident();
        else if (r >= 70) c.variant = pick_variant();
        else if (r >= 55) c.kind = 2'($urandom_range(3));
        else if (r >= 40) c.rev = pick_rev();
      end
    end
    return c;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_tvalid || outcome_q.size() != 0);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $realtime, outcome_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        outcome_q.push_back(table_op_outcome(cur_cmd));
      if (!s_tvalid || s_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_queue.pop_front();
          cur_cmd  = next_cmd;
          s_tvalid <= 1'b1;
          s_tuser  <= next_cmd.op;
          s_tdata  <= {1'b0, next_cmd.variant, next_cmd.kind, next_cmd.rev, next_cmd.ident,
                       next_cmd.row_valid, next_cmd.row};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_outcome.status    = m_tdata[1:0];
        got_outcome.hit_index = m_tdata[5:2];
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none, actual status %0d index %0d",
                   $realtime, got_outcome.status, got_outcome.hit_index);
          fail_count++;
        end else begin
          want_outcome = outcome_q.pop_front();
          if (got_outcome.status !== want_outcome.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $realtime, want_outcome.status, got_outcome.status);
            fail_count++;
          end
          if (got_outcome.hit_index !== want_outcome.hit_index) begin
            $display("%0t hit_index mismatch: expected %0d, actual %0d",
                     $realtime, want_outcome.hit_index, got_outcome.hit_index);
            fail_count++;
          end
        end
        result_count++;
      end
      // one long hold-off so the sender backs up behind the busy block
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    id_pool[0]  = 64'hFFFF_FFFF_FFFF_FFFF;
    id_pool[1]  = 64'h0000_0000_0000_0001;
    id_pool[2]  = rand64() | 64'h1;
    id_pool[3]  = rand64() | 64'h8000_0000_0000_0000;
    rev_pool[0] = 64'h0;
    rev_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    rev_pool[2] = rand64();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, zero identity
    push_cmd(OP_QUERY, 4'hF, 1'b1, 64'h1234_5678_9ABC_DEF0, 64'h0, 2'd0, 16'h0);
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'h0, 64'h0, 2'd0, 16'h0);
    // all-ones key in row 0, exact hit
    push_cmd(OP_WRITE, 4'h0, 1'b1, '1, '1, 2'd3, 16'hFFFF);
    push_cmd(OP_QUERY, 4'h9, 1'b0, '1, '1, 2'd3, 16'hFFFF);
    // same identity and revision in rows 15 and 5 with different kind and variant
    push_cmd(OP_WRITE, 4'hF, 1'b1, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0000);
    push_cmd(OP_WRITE, 4'h5, 1'b1, 64'hA5A5_0000_0000_0001, 64'h7, 2'd1, 16'h1234);
    push_cmd(OP_QUERY, 4'h0, 1'b1, 64'hA5A5_0000_0000_0001, 64'h7, 2'd1, 16'h1234);
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0000);
    // identity and revision match but kind or variant differ
    push_cmd(OP_QUERY, 4'h3, 1'b1, 64'hA5A5_0000_0000_0001, 64'h7, 2'd2, 16'h0000);
    push_cmd(OP_QUERY, 4'h3, 1'b0, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0001);
    // identity only: revision miss
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'hA5A5_0000_0000_0001, 64'h8, 2'd0, 16'h0000);
    push_cmd(OP_QUERY, 4'h0, 1'b0, '1, 64'h0, 2'd3, 16'hFFFF);
    // two full matches, lowest row wins
    push_cmd(OP_WRITE, 4'h5, 1'b1, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0000);
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0000);
    // clearing drops only the valid mark
    push_cmd(OP_WRITE, 4'h5, 1'b0, 64'h0, 64'h0, 2'd0, 16'h0);
    push_cmd(OP_QUERY, 4'hA, 1'b1, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0000);
    push_cmd(OP_WRITE, 4'hF, 1'b0, '1, '1, 2'd3, 16'hFFFF);
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'hA5A5_0000_0000_0001, 64'h7, 2'd0, 16'h0000);
    // a stored zero identity never matches a zero-identity query
    push_cmd(OP_WRITE, 4'h3, 1'b1, 64'h0, 64'h0, 2'd0, 16'h0);
    push_cmd(OP_QUERY, 4'h3, 1'b1, 64'h0, 64'h0, 2'd0, 16'h0);
    // smallest nonzero identity
    push_cmd(OP_WRITE, 4'h1, 1'b1, 64'h1, 64'h0, 2'd2, 16'h8000);
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'h1, 64'h0, 2'd2, 16'h8000);
    push_cmd(OP_QUERY, 4'h0, 1'b0, 64'h1, 64'h1, 2'd2, 16'h8000);
    wait_drained();

    send_idle_pct = 33;
    recv_idle_pct = 69;
    repeat (PHASE_ITEMS) cmd_queue.push_back(make_random_cmd());
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 33;
    repeat (PHASE_ITEMS) cmd_queue.push_back(make_random_cmd());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) cmd_queue.push_back(make_random_cmd());
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
